// ----- rtl/core/murmur2_64b_hash_core_macros.svh -----
// assertion macros for the murmur2 64-bit hash core
// used by murmur2_64b_hash_core.sv, no other dependencies
`ifndef MURMUR2_64B_HASH_CORE_MACROS_SVH
`define MURMUR2_64B_HASH_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MUR64_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mur64 same-cycle check failed");

// next-cycle implication, disabled during reset
`define MUR64_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mur64 next-cycle check failed");

`endif

// ----- rtl/core/mur64_pkg.sv -----
// constants and helpers for the murmur2 64-bit hash core
// no dependencies; used by murmur2_64b_hash_core
`default_nettype none

package mur64_pkg;

   // mixing constants
   localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
   localparam int          MIX_SHIFT = 24;
   localparam int          FIN_SH_A  = 18;
   localparam int          FIN_SH_B  = 22;
   localparam int          FIN_SH_C  = 17;
   localparam int          FIN_SH_D  = 19;

   // stream widths
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 3;
   localparam int LENGTH_W = 32;
   localparam int REQ_W    = 72;
   localparam int HASH_W   = 64;
   localparam int STATE_W  = 3;

   // sequencer states
   localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] ST_K2   = 3'd1;
   localparam logic [STATE_W-1:0] ST_H    = 3'd2;
   localparam logic [STATE_W-1:0] ST_TAIL = 3'd3;
   localparam logic [STATE_W-1:0] ST_F0   = 3'd4;
   localparam logic [STATE_W-1:0] ST_F1   = 3'd5;
   localparam logic [STATE_W-1:0] ST_F2   = 3'd6;
   localparam logic [STATE_W-1:0] ST_F3   = 3'd7;

   // byte mask for a 1 to 3 byte tail
   function automatic logic [WORD_W-1:0] tail_mask(input logic [1:0] cnt);
      logic [WORD_W-1:0] m;
      unique case (cnt)
         2'd1:    m = 32'h0000_00ff;
         2'd2:    m = 32'h0000_ffff;
         2'd3:    m = 32'h00ff_ffff;
         default: m = 32'h0000_0000;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/murmur2_64b_hash_core.sv -----
// MurmurHash64B streaming core built around one shared constant multiplier
// depends on mur64_pkg and murmur2_64b_hash_core_macros.svh
//
// Usage:
//   csr_*  : 64-bit seed write (bits 31:0 start h1, 63:32 start h2), always ready.
//            Sampled on every request transfer whose tuser (first) is set.
//   req_*  : one 32-bit little-endian message word per transfer, with byte
//            count, message length (used on first), first in tuser and last in
//            tlast.
//   rsp_*  : one 64-bit hash per request with tlast set, h1 in bits 63:32.
// Timing: one 32x32 multiplier by the mix constant does every step, one step
//   per cycle unless F3 holds for a full result register. A full word takes the
//   accept multiply, then K2 and H; a 1-3 byte tail the accept, then TAIL; an
//   empty word the accept only. After a last word F0 to F3 finalize and F3
//   fills the result register. req_tready is high only while the sequencer is idle.
// Reset: clears the state, hash halves, parity, last flag, seed and result valid.
// Stall: a finished hash waits in the result register; if another hash is
//   done while it waits, the sequencer holds in the last finalize step and
//   accepts nothing until rsp_tready frees the register.
`default_nettype none
`include "murmur2_64b_hash_core_macros.svh"

module murmur2_64b_hash_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // seed write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mur64_pkg::HASH_W-1:0]     csr_data,
   // request stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // data_word[31:0], byte_count[34:32], message_length[66:35], zero pad
   input  wire logic [mur64_pkg::REQ_W-1:0]      req_tdata,
   // first[0]
   input  wire logic                             req_tuser,
   input  wire logic                             req_tlast,
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // hash_value[63:0]
   output logic [mur64_pkg::HASH_W-1:0]          rsp_tdata
);

   logic [mur64_pkg::STATE_W-1:0] state_ff, state_in;
   logic [31:0] h1_ff, h1_in;
   logic [31:0] h2_ff, h2_in;
   logic        parity_ff, parity_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] fa_ff, fa_in;
   logic [31:0] fb_ff, fb_in;
   logic        last_ff, last_in;
   logic [mur64_pkg::HASH_W-1:0] seed_ff, seed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [mur64_pkg::HASH_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0] req_word;
   logic [2:0]  req_count;
   logic [31:0] req_length;
   logic        req_xfer;
   logic        rsp_free;
   logic [31:0] mul_op;
   logic [31:0] mul_prod;
   logic [31:0] h1_base;
   logic [31:0] h2_base;

   // request field unpacking
   assign req_word   = req_tdata[31:0];
   assign req_count  = req_tdata[34:32];
   assign req_length = req_tdata[66:35];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == mur64_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // halves as seen by an accepted item, taken from the seed on first
   assign h1_base = req_tuser ? (seed_ff[31:0] ^ req_length) : h1_ff;
   assign h2_base = req_tuser ? seed_ff[63:32] : h2_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         mur64_pkg::ST_IDLE: mul_op = req_word;
         mur64_pkg::ST_K2:   mul_op = k_ff ^ (k_ff >> mur64_pkg::MIX_SHIFT);
         mur64_pkg::ST_H:    mul_op = parity_ff ? h2_ff : h1_ff;
         mur64_pkg::ST_TAIL: mul_op = h2_ff ^ k_ff;
         mur64_pkg::ST_F0:   mul_op = h1_ff ^ (h2_ff >> mur64_pkg::FIN_SH_A);
         mur64_pkg::ST_F1:   mul_op = h2_ff ^ (fa_ff >> mur64_pkg::FIN_SH_B);
         mur64_pkg::ST_F2:   mul_op = fa_ff ^ (fb_ff >> mur64_pkg::FIN_SH_C);
         mur64_pkg::ST_F3:   mul_op = fb_ff ^ (fa_ff >> mur64_pkg::FIN_SH_D);
         default:            mul_op = req_word;
      endcase
   end

   // the one multiplier, low 32 bits kept
   assign mul_prod = mul_op * mur64_pkg::MIX_MUL;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      parity_in    = parity_ff;
      k_in         = k_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      last_in      = last_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         seed_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mur64_pkg::ST_IDLE: begin
            if (req_xfer) begin
               last_in = req_tlast;
               h1_in   = h1_base;
               h2_in   = h2_base;
               if (req_tuser) begin
                  parity_in = 1'b0;
               end
               priority if (req_count[2]) begin
                  // full word: first scramble multiply now
                  k_in     = mul_prod;
                  state_in = mur64_pkg::ST_K2;
               end else if (req_count[1:0] != 2'd0) begin
                  k_in     = req_word & mur64_pkg::tail_mask(req_count[1:0]);
                  state_in = mur64_pkg::ST_TAIL;
               end else if (req_tlast) begin
                  state_in = mur64_pkg::ST_F0;
               end else begin
                  state_in = mur64_pkg::ST_IDLE;
               end
            end
         end
         mur64_pkg::ST_K2: begin
            k_in     = mul_prod;
            state_in = mur64_pkg::ST_H;
         end
         mur64_pkg::ST_H: begin
            // fold scrambled word into the half picked by parity
            if (parity_ff) begin
               h2_in = mul_prod ^ k_ff;
            end else begin
               h1_in = mul_prod ^ k_ff;
            end
            parity_in = !parity_ff;
            state_in  = last_ff ? mur64_pkg::ST_F0 : mur64_pkg::ST_IDLE;
         end
         mur64_pkg::ST_TAIL: begin
            h2_in    = mul_prod;
            state_in = last_ff ? mur64_pkg::ST_F0 : mur64_pkg::ST_IDLE;
         end
         mur64_pkg::ST_F0: begin
            fa_in    = mul_prod;
            state_in = mur64_pkg::ST_F1;
         end
         mur64_pkg::ST_F1: begin
            fb_in    = mul_prod;
            state_in = mur64_pkg::ST_F2;
         end
         mur64_pkg::ST_F2: begin
            fa_in    = mul_prod;
            state_in = mur64_pkg::ST_F3;
         end
         mur64_pkg::ST_F3: begin
            // hold here until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {fa_ff, mul_prod};
               state_in     = mur64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mur64_pkg::ST_IDLE;
         end
      endcase
   end

   // control and hash state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mur64_pkg::ST_IDLE;
         h1_ff        <= '0;
         h2_ff        <= '0;
         parity_ff    <= 1'b0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h1_ff        <= h1_in;
         h2_ff        <= h2_in;
         parity_ff    <= parity_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer checks
   `MUR64_ASSERT_SAME(a_busy_not_ready, state_ff != mur64_pkg::ST_IDLE, !req_tready)
   `MUR64_ASSERT_NEXT(a_full_word_to_k2, req_xfer && req_count[2], state_ff == mur64_pkg::ST_K2)
   `MUR64_ASSERT_NEXT(a_k2_to_fold, state_ff == mur64_pkg::ST_K2, state_ff == mur64_pkg::ST_H)
   `MUR64_ASSERT_NEXT(a_empty_last_final, req_xfer && req_tlast && req_count == 3'd0, state_ff == mur64_pkg::ST_F0)

endmodule

`default_nettype wire
